[design/aesi_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ANSI escape interpreter package
// Shared constants, control and status structs, and the SGR attribute update.
// ----------------------------------------------------------------------------
package aesi_pkg;

   // Screen and sequence limits
   localparam int MAX_PARAMS  = 10;
   localparam int SCREEN_COLS = 80;
   localparam int SCREEN_ROWS = 25;
   localparam int MAX_SEQ_LEN = 75;

   // Field widths
   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int LEN_W  = 7;
   localparam int CNT_W  = $clog2(MAX_PARAMS + 1);
   localparam int IDX_W  = $clog2(MAX_PARAMS);
   localparam int UPC_W  = 3;

   localparam logic [COL_W-1:0] COL_MAX = COL_W'(SCREEN_COLS - 1);
   localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(SCREEN_ROWS - 1);

   // Characters
   localparam logic [7:0] CH_ESC    = 8'd27;
   localparam logic [7:0] CH_LBRACK = 8'h5b;
   localparam logic [7:0] CH_SEMI   = 8'h3b;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CMD_UP    = 8'h41;
   localparam logic [7:0] CMD_DOWN  = 8'h42;
   localparam logic [7:0] CMD_RIGHT = 8'h43;
   localparam logic [7:0] CMD_LEFT  = 8'h44;
   localparam logic [7:0] CMD_HOME  = 8'h48;
   localparam logic [7:0] CMD_HVP   = 8'h66;
   localparam logic [7:0] CMD_SAVE  = 8'h73;
   localparam logic [7:0] CMD_REST  = 8'h75;
   localparam logic [7:0] CMD_CLEAR = 8'h4a;
   localparam logic [7:0] CMD_EOL   = 8'h4b;
   localparam logic [7:0] CMD_EOL_L = 8'h6b;
   localparam logic [7:0] CMD_SGR   = 8'h6d;

   // Result actions
   localparam logic [2:0] ACT_SWALLOW = 3'd0;
   localparam logic [2:0] ACT_PRINT   = 3'd1;
   localparam logic [2:0] ACT_MOVE    = 3'd2;
   localparam logic [2:0] ACT_CLEAR   = 3'd3;
   localparam logic [2:0] ACT_EOL     = 3'd4;
   localparam logic [2:0] ACT_ATTR    = 3'd5;

   // SGR parameter codes
   localparam logic [15:0] SGR_RESET     = 16'd0;
   localparam logic [15:0] SGR_BOLD      = 16'd1;
   localparam logic [15:0] SGR_UNDERLINE = 16'd4;
   localparam logic [15:0] SGR_BLINK     = 16'd5;
   localparam logic [15:0] SGR_REVERSE   = 16'd7;
   localparam logic [15:0] SGR_CONCEAL   = 16'd8;
   localparam logic [15:0] SGR_FG_LO     = 16'd30;
   localparam logic [15:0] SGR_FG_HI     = 16'd37;
   localparam logic [15:0] SGR_BG_LO     = 16'd40;
   localparam logic [15:0] SGR_BG_HI     = 16'd47;
   localparam logic [15:0] CLEAR_ALL     = 16'd2;

   // Attribute values
   localparam logic [7:0] ATTR_RESET   = 8'h07;
   localparam logic [7:0] ATTR_BOLD    = 8'h08;
   localparam logic [7:0] ATTR_BLINK   = 8'h80;
   localparam logic [7:0] ATTR_CONCEAL = 8'h00;

   // Datapath operations
   localparam logic [2:0] OP_NOP      = 3'd0;
   localparam logic [2:0] OP_LATCH    = 3'd1;
   localparam logic [2:0] OP_CLASSIFY = 3'd2;
   localparam logic [2:0] OP_SGR_INIT = 3'd3;
   localparam logic [2:0] OP_SGR_STEP = 3'd4;
   localparam logic [2:0] OP_EMIT     = 3'd5;

   // Jump conditions
   localparam logic [2:0] COND_ALWAYS    = 3'd0;
   localparam logic [2:0] COND_REQ       = 3'd1;
   localparam logic [2:0] COND_SGR       = 3'd2;
   localparam logic [2:0] COND_WALK_DONE = 3'd3;
   localparam logic [2:0] COND_OUT_FREE  = 3'd4;

   // Control word fields
   typedef struct packed {
      logic             rdy;
      logic [2:0]       op;
      logic [2:0]       cond;
      logic [UPC_W-1:0] jt;
      logic [UPC_W-1:0] jf;
   } uword_type;

   // Sequencer to datapath
   typedef struct packed {
      logic       rdy;
      logic [2:0] op;
   } ctrl_type;

   // Datapath to sequencer
   typedef struct packed {
      logic sgr;
      logic walk_done;
      logic out_free;
   } status_type;

   // PC colour order is the bit reversal of the ANSI colour index
   function automatic logic [2:0] pc_colour(input logic [2:0] i);
      return {i[0], i[1], i[2]};
   endfunction

   // Apply one SGR parameter to an attribute byte
   function automatic logic [7:0] sgr_apply(input logic [7:0] a, input logic [15:0] v);
      logic [7:0]  r;
      logic [15:0] off;
      r   = a;
      off = 16'd0;
      priority if (v == SGR_RESET) begin
         r = ATTR_RESET;
      end else if (v == SGR_BOLD) begin
         r = a | ATTR_BOLD;
      end else if (v == SGR_UNDERLINE) begin
         r = a;
      end else if (v == SGR_BLINK) begin
         r = a | ATTR_BLINK;
      end else if (v == SGR_REVERSE) begin
         r = {a[7], a[2:0], a[3], a[6:4]};
      end else if (v == SGR_CONCEAL) begin
         r = ATTR_CONCEAL;
      end else if (v >= SGR_FG_LO && v <= SGR_FG_HI) begin
         off = v - SGR_FG_LO;
         r   = {a[7:3], pc_colour(off[2:0])};
      end else if (v >= SGR_BG_LO && v <= SGR_BG_HI) begin
         off = v - SGR_BG_LO;
         r   = {a[7], pc_colour(off[2:0]), a[3:0]};
      end else begin
         r = a;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[design/ansi_escape_sequence_interpreter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ANSI escape sequence interpreter
// Parses ESC [ sequences in a terminal byte stream into cursor, erase and
// colour attribute actions; other bytes come out as print requests.
//
//   Channel  Dir  Signals                    Payload
//   req      in   req_tvalid/tready/tdata    data_byte, cursor_col, cursor_row
//   rsp      out  rsp_tvalid/tready/tdata    action, glyph, target_col,
//                                            target_row, attribute
//
// One byte at a time; an SGR final byte with N stored parameters (up to 10)
// also runs the microprogram loop that walks the parameter store one entry
// per step.
// Reset is synchronous; it clears the parser and sets the attribute to 0x07.
// A stalled result holds in the output register; the next byte is taken
// meanwhile and its own result waits only at the emit step.
// ----------------------------------------------------------------------------
module ansi_escape_sequence_interpreter
   import aesi_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // [7:0] data_byte, [14:8] cursor_col, [19:15] cursor_row, [23:20] zero
   input  wire logic [23:0] req_tdata,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // [2:0] action, [10:3] glyph, [17:11] target_col, [22:18] target_row,
   // [30:23] attribute, [31] zero
   output      logic [31:0] rsp_tdata
);

   ctrl_type         ctl;
   status_type       sts;
   logic [2:0]       out_action;
   logic [7:0]       out_glyph;
   logic [COL_W-1:0] out_col;
   logic [ROW_W-1:0] out_row;
   logic [7:0]       out_attr;

   // Microcode sequencer
   aesi_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .sts        (sts),
      .ctl        (ctl)
   );

   // Datapath
   aesi_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .sts        (sts),
      .req_tvalid (req_tvalid),
      .in_byte    (req_tdata[7:0]),
      .in_col     (req_tdata[14:8]),
      .in_row     (req_tdata[19:15]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .out_action (out_action),
      .out_glyph  (out_glyph),
      .out_col    (out_col),
      .out_row    (out_row),
      .out_attr   (out_attr)
   );

   assign req_tready = ctl.rdy;
   assign rsp_tdata  = {1'b0, out_attr, out_row, out_col, out_glyph, out_action};

endmodule
`default_nettype wire

[design/aesi_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ANSI escape interpreter sequencer
// Step counter and microcode ROM; each control word selects a datapath
// operation and a conditional two-way jump.
// ----------------------------------------------------------------------------
module aesi_seq
   import aesi_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   input  wire status_type sts,
   output      ctrl_type   ctl
);

   localparam logic [UPC_W-1:0] ST_WAIT     = UPC_W'(0);
   localparam logic [UPC_W-1:0] ST_CLASSIFY = UPC_W'(1);
   localparam logic [UPC_W-1:0] ST_SGR_INIT = UPC_W'(2);
   localparam logic [UPC_W-1:0] ST_SGR_STEP = UPC_W'(3);
   localparam logic [UPC_W-1:0] ST_EMIT     = UPC_W'(4);

   logic [UPC_W-1:0] upc_ff, upc_in;
   uword_type        uw;
   logic             taken;

   // Microprogram
   always_comb begin
      unique case (upc_ff)
         ST_WAIT:     uw = '{rdy: 1'b1, op: OP_LATCH,    cond: COND_REQ,
                             jt: ST_CLASSIFY, jf: ST_WAIT};
         ST_CLASSIFY: uw = '{rdy: 1'b0, op: OP_CLASSIFY, cond: COND_SGR,
                             jt: ST_SGR_INIT, jf: ST_EMIT};
         ST_SGR_INIT: uw = '{rdy: 1'b0, op: OP_SGR_INIT, cond: COND_ALWAYS,
                             jt: ST_SGR_STEP, jf: ST_SGR_STEP};
         ST_SGR_STEP: uw = '{rdy: 1'b0, op: OP_SGR_STEP, cond: COND_WALK_DONE,
                             jt: ST_EMIT, jf: ST_SGR_STEP};
         ST_EMIT:     uw = '{rdy: 1'b0, op: OP_EMIT,     cond: COND_OUT_FREE,
                             jt: ST_WAIT, jf: ST_EMIT};
         default:     uw = '{rdy: 1'b0, op: OP_NOP,      cond: COND_ALWAYS,
                             jt: ST_WAIT, jf: ST_WAIT};
      endcase
   end

   // Evaluate jump condition
   always_comb begin
      unique case (uw.cond)
         COND_ALWAYS:    taken = 1'b1;
         COND_REQ:       taken = req_tvalid;
         COND_SGR:       taken = sts.sgr;
         COND_WALK_DONE: taken = sts.walk_done;
         COND_OUT_FREE:  taken = sts.out_free;
         default:        taken = 1'b1;
      endcase
   end

   assign upc_in = taken ? uw.jt : uw.jf;

   // Advance step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= ST_WAIT;
      end else begin
         upc_ff <= upc_in;
      end
   end

   assign ctl = '{rdy: uw.rdy, op: uw.op};

endmodule
`default_nettype wire

[design/aesi_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ANSI escape interpreter datapath
// Parser state, parameter store, cursor arithmetic, attribute register and
// the result register, all stepped by the sequencer's operation code.
// ----------------------------------------------------------------------------
module aesi_dp
   import aesi_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ctrl_type         ctl,
   output      status_type       sts,
   input  wire logic             req_tvalid,
   input  wire logic [7:0]       in_byte,
   input  wire logic [COL_W-1:0] in_col,
   input  wire logic [ROW_W-1:0] in_row,
   output      logic             rsp_tvalid,
   input  wire logic             rsp_tready,
   output      logic [2:0]       out_action,
   output      logic [7:0]       out_glyph,
   output      logic [COL_W-1:0] out_col,
   output      logic [ROW_W-1:0] out_row,
   output      logic [7:0]       out_attr
);

   // Latched item
   logic [7:0]       byte_ff, byte_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   // Parser state
   logic             in_seq_ff, in_seq_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [15:0]      acc_ff, acc_in;
   logic             nonempty_ff, nonempty_in;
   logic [7:0]       attr_ff, attr_in;
   logic [COL_W-1:0] saved_col_ff, saved_col_in;
   logic [ROW_W-1:0] saved_row_ff, saved_row_in;
   logic [CNT_W-1:0] walk_ff, walk_in;
   logic             sgr_ff, sgr_in;

   // Parameter store
   logic [15:0]      pv_ff [MAX_PARAMS];
   logic             pv_we;
   logic [IDX_W-1:0] pv_wa;
   logic [15:0]      pv_wd;

   // Pending result
   logic [2:0]       res_act_ff, res_act_in;
   logic [7:0]       res_glyph_ff, res_glyph_in;
   logic [COL_W-1:0] res_col_ff, res_col_in;
   logic [ROW_W-1:0] res_row_ff, res_row_in;

   // Output register
   logic             ovalid_ff, ovalid_in;
   logic [2:0]       oact_ff, oact_in;
   logic [7:0]       oglyph_ff, oglyph_in;
   logic [COL_W-1:0] ocol_ff, ocol_in;
   logic [ROW_W-1:0] orow_ff, orow_in;
   logic [7:0]       oattr_ff, oattr_in;

   // Classification terms
   logic [LEN_W:0]   newlen;
   logic             is_digit, is_cont, first, ends;
   logic [19:0]      acc_prod;
   logic             push_ok;
   logic [15:0]      p0, p1, n0;
   logic [16:0]      row_sum, col_sum;
   logic [ROW_W-1:0] tr_up, tr_down, tr_abs;
   logic [COL_W-1:0] tc_right, tc_left, tc_abs;
   logic             out_free, walk_done;

   assign out_free  = !ovalid_ff || rsp_tready;
   assign walk_done = (walk_ff == cnt_ff);

   // Byte class and digit accumulate
   always_comb begin
      newlen   = {1'b0, len_ff} + 1'b1;
      is_digit = (byte_ff >= CH_ZERO) && (byte_ff <= CH_NINE);
      is_cont  = is_digit || (byte_ff == CH_LBRACK) || (byte_ff == CH_SEMI);
      first    = (len_ff <= LEN_W'(1));
      ends     = !is_cont || (first && byte_ff != CH_LBRACK)
                 || (newlen > (LEN_W+1)'(MAX_SEQ_LEN));
      acc_prod = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                 + {16'd0, byte_ff[3:0] - CH_ZERO[3:0]};
      push_ok  = (cnt_ff < CNT_W'(MAX_PARAMS));
   end

   // Effective first two parameters, counting the pending field
   always_comb begin
      if (cnt_ff != '0) begin
         p0 = pv_ff[0];
      end else if (nonempty_ff) begin
         p0 = acc_ff;
      end else begin
         p0 = 16'd0;
      end
      if (cnt_ff > CNT_W'(1)) begin
         p1 = pv_ff[1];
      end else if (cnt_ff == CNT_W'(1) && nonempty_ff) begin
         p1 = acc_ff;
      end else begin
         p1 = 16'd0;
      end
      n0 = (p0 == 16'd0) ? 16'd1 : p0;
   end

   // Cursor targets, clamped to the screen
   always_comb begin
      row_sum  = {{(17-ROW_W){1'b0}}, row_ff} + {1'b0, n0};
      col_sum  = {{(17-COL_W){1'b0}}, col_ff} + {1'b0, n0};
      tr_up    = (n0 > {{(16-ROW_W){1'b0}}, row_ff}) ? '0 : row_ff - n0[ROW_W-1:0];
      tr_down  = (row_sum > 17'(ROW_MAX)) ? ROW_MAX : row_sum[ROW_W-1:0];
      tc_left  = (n0 > {{(16-COL_W){1'b0}}, col_ff}) ? '0 : col_ff - n0[COL_W-1:0];
      tc_right = (col_sum > 17'(COL_MAX)) ? COL_MAX : col_sum[COL_W-1:0];
      if (p0 == 16'd0) begin
         tr_abs = '0;
      end else if (p0 > 16'(SCREEN_ROWS)) begin
         tr_abs = ROW_MAX;
      end else begin
         tr_abs = p0[ROW_W-1:0] - 1'b1;
      end
      if (p1 == 16'd0) begin
         tc_abs = '0;
      end else if (p1 > 16'(SCREEN_COLS)) begin
         tc_abs = COL_MAX;
      end else begin
         tc_abs = p1[COL_W-1:0] - 1'b1;
      end
   end

   // Operation decode
   always_comb begin
      byte_in      = byte_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      in_seq_in    = in_seq_ff;
      len_in       = len_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      nonempty_in  = nonempty_ff;
      attr_in      = attr_ff;
      saved_col_in = saved_col_ff;
      saved_row_in = saved_row_ff;
      walk_in      = walk_ff;
      sgr_in       = sgr_ff;
      pv_we        = 1'b0;
      pv_wa        = cnt_ff[IDX_W-1:0];
      pv_wd        = acc_ff;
      res_act_in   = res_act_ff;
      res_glyph_in = res_glyph_ff;
      res_col_in   = res_col_ff;
      res_row_in   = res_row_ff;
      ovalid_in    = ovalid_ff && !rsp_tready;
      oact_in      = oact_ff;
      oglyph_in    = oglyph_ff;
      ocol_in      = ocol_ff;
      orow_in      = orow_ff;
      oattr_in     = oattr_ff;

      unique case (ctl.op)
         OP_LATCH: begin
            // Take item, clamp reported cursor
            if (req_tvalid) begin
               byte_in = in_byte;
               col_in  = (in_col > COL_MAX) ? COL_MAX : in_col;
               row_in  = (in_row > ROW_MAX) ? ROW_MAX : in_row;
            end
         end
         OP_CLASSIFY: begin
            res_act_in   = ACT_SWALLOW;
            res_glyph_in = 8'd0;
            res_col_in   = col_ff;
            res_row_in   = row_ff;
            sgr_in       = 1'b0;
            if (!in_seq_ff) begin
               if (byte_ff == CH_ESC) begin
                  in_seq_in   = 1'b1;
                  len_in      = LEN_W'(1);
                  cnt_in      = '0;
                  acc_in      = 16'd0;
                  nonempty_in = 1'b0;
               end else begin
                  res_act_in   = ACT_PRINT;
                  res_glyph_in = byte_ff;
               end
            end else if (!ends) begin
               // Collect digits and separators
               if (!first) begin
                  if (is_digit) begin
                     acc_in      = (acc_prod > 20'd65535) ? 16'hffff : acc_prod[15:0];
                     nonempty_in = 1'b1;
                  end else if (byte_ff == CH_SEMI) begin
                     pv_we       = push_ok;
                     cnt_in      = push_ok ? cnt_ff + 1'b1 : cnt_ff;
                     acc_in      = 16'd0;
                     nonempty_in = 1'b0;
                  end
               end
               len_in = newlen[LEN_W-1:0];
            end else begin
               // Final byte: flush pending field and run the command
               in_seq_in = 1'b0;
               len_in    = '0;
               if (!first) begin
                  if (nonempty_ff && push_ok) begin
                     pv_we  = 1'b1;
                     cnt_in = cnt_ff + 1'b1;
                  end
                  priority case (byte_ff)
                     CMD_HOME, CMD_HVP: begin
                        res_act_in = ACT_MOVE;
                        res_col_in = tc_abs;
                        res_row_in = tr_abs;
                     end
                     CMD_UP: begin
                        res_act_in = ACT_MOVE;
                        res_row_in = tr_up;
                     end
                     CMD_DOWN: begin
                        res_act_in = ACT_MOVE;
                        res_row_in = tr_down;
                     end
                     CMD_RIGHT: begin
                        res_act_in = ACT_MOVE;
                        res_col_in = tc_right;
                     end
                     CMD_LEFT: begin
                        res_act_in = ACT_MOVE;
                        res_col_in = tc_left;
                     end
                     CMD_SAVE: begin
                        saved_col_in = col_ff;
                        saved_row_in = row_ff;
                     end
                     CMD_REST: begin
                        res_act_in = ACT_MOVE;
                        res_col_in = saved_col_ff;
                        res_row_in = saved_row_ff;
                     end
                     CMD_CLEAR: begin
                        if (p0 == CLEAR_ALL) begin
                           res_act_in = ACT_CLEAR;
                           res_col_in = '0;
                           res_row_in = '0;
                        end
                     end
                     CMD_EOL, CMD_EOL_L: begin
                        res_act_in = ACT_EOL;
                     end
                     CMD_SGR: begin
                        res_act_in = ACT_ATTR;
                        sgr_in     = 1'b1;
                     end
                     default: begin
                        res_act_in = ACT_SWALLOW;
                     end
                  endcase
               end
            end
         end
         OP_SGR_INIT: begin
            // Empty parameter list acts as a single reset
            if (cnt_ff == '0) begin
               attr_in = ATTR_RESET;
            end
            walk_in = '0;
         end
         OP_SGR_STEP: begin
            if (!walk_done) begin
               attr_in = sgr_apply(attr_ff, pv_ff[walk_ff[IDX_W-1:0]]);
               walk_in = walk_ff + 1'b1;
            end
         end
         OP_EMIT: begin
            // Load output register once it is free
            if (out_free) begin
               ovalid_in = 1'b1;
               oact_in   = res_act_ff;
               oglyph_in = res_glyph_ff;
               ocol_in   = res_col_ff;
               orow_in   = res_row_ff;
               oattr_in  = attr_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_seq_ff    <= 1'b0;
         len_ff       <= '0;
         cnt_ff       <= '0;
         acc_ff       <= 16'd0;
         nonempty_ff  <= 1'b0;
         attr_ff      <= ATTR_RESET;
         saved_col_ff <= '0;
         saved_row_ff <= '0;
         walk_ff      <= '0;
         sgr_ff       <= 1'b0;
         ovalid_ff    <= 1'b0;
      end else begin
         in_seq_ff    <= in_seq_in;
         len_ff       <= len_in;
         cnt_ff       <= cnt_in;
         acc_ff       <= acc_in;
         nonempty_ff  <= nonempty_in;
         attr_ff      <= attr_in;
         saved_col_ff <= saved_col_in;
         saved_row_ff <= saved_row_in;
         walk_ff      <= walk_in;
         sgr_ff       <= sgr_in;
         ovalid_ff    <= ovalid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      res_act_ff   <= res_act_in;
      res_glyph_ff <= res_glyph_in;
      res_col_ff   <= res_col_in;
      res_row_ff   <= res_row_in;
      oact_ff      <= oact_in;
      oglyph_ff    <= oglyph_in;
      ocol_ff      <= ocol_in;
      orow_ff      <= orow_in;
      oattr_ff     <= oattr_in;
      if (pv_we) begin
         pv_ff[pv_wa] <= pv_wd;
      end
   end

   // SGR branch is decided in the classify step itself
   assign sts        = '{sgr: sgr_in, walk_done: walk_done, out_free: out_free};
   assign rsp_tvalid = ovalid_ff;
   assign out_action = oact_ff;
   assign out_glyph  = oglyph_ff;
   assign out_col    = ocol_ff;
   assign out_row    = orow_ff;
   assign out_attr   = oattr_ff;

endmodule
`default_nettype wire

[design/aesi_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ANSI escape interpreter port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module aesi_checker
   import aesi_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Block the byte after a transaction while it is classified
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while one is in work");

   // Glyph only on print requests, action within its codes
   a_action_glyph: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2:0] <= ACT_ATTR)
                     && (rsp_tdata[2:0] == ACT_PRINT || rsp_tdata[10:3] == 8'd0))
      else $error("bad action or glyph");

   // Targets stay on screen
   a_target_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[17:11] <= COL_MAX) && (rsp_tdata[22:18] <= ROW_MAX))
      else $error("target off screen");

endmodule

bind ansi_escape_sequence_interpreter aesi_checker u_aesi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
